[rtl/lfu_pkg.sv]
// lfu_pkg: shared constants and types for the lfu cache with lru tie-break
// no dependencies
`timescale 1ns / 1ps
package lfu_pkg;
    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int KEY_W          = 32;
    localparam int VAL_W          = 31;
    localparam int CAP_W          = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_VSCAN,
        ST_UPDATE
    } t_state;
endpackage

[rtl/lfu_seq.sv]
// lfu_seq: sequencer state register and next-state logic
// depends on lfu_pkg
`timescale 1ns / 1ps
module lfu_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_scan_last,
    input  logic           i_need_vscan,
    input  logic           i_skip,
    output lfu_pkg::t_state o_state
);
    import lfu_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_start) n_state = ST_SCAN;
            ST_SCAN:   if (i_scan_last) n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (i_skip)            n_state = ST_UPDATE;
                else if (i_need_vscan) n_state = ST_VSCAN;
                else                   n_state = ST_UPDATE;
            end
            ST_VSCAN:  if (i_scan_last) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    assign o_state = r_state;
endmodule

[rtl/lfu_cache_lru_tiebreak.sv]
// lfu_cache_lru_tiebreak: top level of the lfu cache with lru tie-break
// uses lfu_pkg and lfu_seq
// operations without a victim search: get, put hit, put into a free slot, put at
// capacity zero; every other put runs the victim search as well
// one operation at a time: busy from start until the result strobe, next start taken
// in the strobe cycle; a scan pointer walks the slots once for key match and free slot,
// once more for the victim
// synchronous active-low reset clears valid bits, capacity back to 16
// the receiver cannot stall: o_done is high for one cycle per transfer
`timescale 1ns / 1ps
module lfu_cache_lru_tiebreak #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0] i_cfg_data,
    input  logic                      i_opcode,
    input  logic [lfu_pkg::KEY_W-1:0] i_key,
    input  logic [lfu_pkg::VAL_W-1:0] i_value,
    output logic                      o_done,
    output logic                      o_hit,
    output logic [lfu_pkg::VAL_W-1:0] o_read_value,
    output logic                      o_evicted,
    output logic [lfu_pkg::KEY_W-1:0] o_evicted_key
);
    import lfu_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NW = $clog2(ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // slot storage: arrays indexed by the scan pointer or the chosen slot
    logic [ENTRIES-1:0]    r_valid;
    logic [KEY_W-1:0]      r_ekey  [ENTRIES];
    logic [VAL_W-1:0]      r_edata [ENTRIES];
    logic [COUNT_BITS-1:0] r_cnt   [ENTRIES];
    logic [IW-1:0]         r_rank  [ENTRIES];

    logic [CAP_W-1:0] r_cap;
    // latched operation
    logic             r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    // scan results
    logic [IW-1:0]    r_ptr;
    logic             r_found;
    logic [IW-1:0]    r_slot;
    logic             r_has_free;
    logic [IW-1:0]    r_free;
    logic [NW-1:0]    r_nvalid;
    logic             r_vfound;
    logic [IW-1:0]    r_vic;

    t_state state;
    logic   scan_last, need_vscan, skip;
    logic [NW-1:0] cap_eff;

    assign scan_last = (r_ptr == IW'(ENTRIES - 1));
    assign cap_eff   = (int'(r_cap) > ENTRIES) ? NW'(ENTRIES) : NW'(r_cap);
    // put with capacity zero, any hit, or get miss: no victim search
    assign skip       = r_found || (r_op == OP_GET) || (cap_eff == '0);
    assign need_vscan = (r_nvalid >= cap_eff) || !r_has_free;

    lfu_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start && !busy),
        .i_scan_last (scan_last),
        .i_need_vscan(need_vscan),
        .i_skip      (skip),
        .o_state     (state)
    );

    assign busy = (state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cap <= CAP_RESET;
        else if (i_cfg_we) r_cap <= i_cfg_data;
    end

    // victim compare: a single compare unit, one slot per cycle
    logic better;
    always_comb begin
        better = r_valid[r_ptr] && (!r_vfound ||
                 (r_cnt[r_ptr] < r_cnt[r_vic]) ||
                 (r_cnt[r_ptr] == r_cnt[r_vic] && r_rank[r_ptr] > r_rank[r_vic]));
    end

    logic            do_insert;
    logic [IW-1:0]   ins_slot;
    logic            upd_hit;
    assign upd_hit   = r_found && (r_op == OP_GET || cap_eff != '0);
    assign do_insert = !r_found && r_op == OP_PUT && cap_eff != '0 &&
                       (r_vfound || (r_has_free && r_nvalid < cap_eff));
    assign ins_slot  = r_vfound ? r_vic : r_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
            o_done  <= 1'b0;
        end else begin
            // strobe is registered: high in the cycle after the update step
            o_done <= (state == ST_UPDATE);
            unique case (state)
                ST_IDLE: if (start) begin
                    r_op <= i_opcode; r_key <= i_key; r_val <= i_value;
                    r_ptr <= '0; r_found <= 1'b0; r_has_free <= 1'b0;
                    r_nvalid <= '0; r_vfound <= 1'b0;
                end
                ST_SCAN: begin
                    if (r_valid[r_ptr]) begin
                        r_nvalid <= r_nvalid + NW'(1);
                        if (r_ekey[r_ptr] == r_key && !r_found) begin
                            r_found <= 1'b1; r_slot <= r_ptr;
                        end
                    end else if (!r_has_free) begin
                        r_has_free <= 1'b1; r_free <= r_ptr;
                    end
                    r_ptr <= scan_last ? '0 : r_ptr + IW'(1);
                end
                ST_DECIDE: r_ptr <= '0;
                ST_VSCAN: begin
                    if (better) begin
                        r_vfound <= 1'b1; r_vic <= r_ptr;
                    end
                    r_ptr <= scan_last ? '0 : r_ptr + IW'(1);
                end
                ST_UPDATE: begin
                    o_hit         <= r_found && (r_op == OP_GET || cap_eff != '0);
                    o_read_value  <= (r_found && r_op == OP_GET) ? r_edata[r_slot] : '0;
                    o_evicted     <= do_insert && r_vfound;
                    o_evicted_key <= (do_insert && r_vfound) ? r_ekey[r_vic] : '0;
                    // rank update across all slots: independent per-slot adjust
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (upd_hit) begin
                            if (IW'(i) == r_slot) r_rank[i] <= '0;
                            else if (r_valid[i] && r_rank[i] < r_rank[r_slot])
                                r_rank[i] <= r_rank[i] + IW'(1);
                        end else if (do_insert) begin
                            if (IW'(i) == ins_slot) r_rank[i] <= '0;
                            else if (r_valid[i]) begin
                                if (r_vfound && r_rank[i] > r_rank[r_vic])
                                    r_rank[i] <= r_rank[i];
                                else
                                    r_rank[i] <= r_rank[i] + IW'(1);
                            end
                        end
                    end
                    if (upd_hit) begin
                        if (r_cnt[r_slot] != CNT_MAX)
                            r_cnt[r_slot] <= r_cnt[r_slot] + COUNT_BITS'(1);
                        if (r_op == OP_PUT) r_edata[r_slot] <= r_val;
                    end else if (do_insert) begin
                        r_valid[ins_slot] <= 1'b1;
                        r_ekey[ins_slot]  <= r_key;
                        r_edata[ins_slot] <= r_val;
                        r_cnt[ins_slot]   <= COUNT_BITS'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // result strobe only leaves the update step
    a_done_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(state) == ST_UPDATE) else $error("strobe without update");
    // a get never evicts
    a_get_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == ST_UPDATE && r_op == OP_GET) |=> !o_evicted)
        else $error("get evicted");
    // victim search only runs on a put miss
    a_vscan_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        state == ST_VSCAN |-> (r_op == OP_PUT && !r_found))
        else $error("victim scan outside put miss");
endmodule
